// ===== src/damped_spring_force_3d_macros.svh =====
// Assertion macros shared by the damped spring force checker.
`ifndef DAMPED_SPRING_FORCE_3D_MACROS_SVH
`define DAMPED_SPRING_FORCE_3D_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dsf3d_pkg.sv =====
// Types and constants shared by the damped spring force block.
`timescale 1ns / 1ps

package dsf3d_pkg;

    localparam int FRAC      = 16;
    localparam int MAX_BALLS = 1024;
    localparam int IDX_W     = $clog2(MAX_BALLS);

    localparam logic [60:0] TERM_CAP  = {1'b1, 60'd0};
    localparam logic [30:0] FORCE_MAX = '1;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_STIFFNESS   = 3'd0;
    localparam t_cfg_idx CFG_DAMPING     = 3'd1;
    localparam t_cfg_idx CFG_REST_LENGTH = 3'd2;
    localparam t_cfg_idx CFG_BREAK_LIMIT = 3'd3;
    localparam t_cfg_idx CFG_BREAK_EN    = 3'd4;
    localparam t_cfg_idx CFG_TOP_INDEX   = 3'd5;
    localparam t_cfg_idx CFG_BOT_INDEX   = 3'd6;

    typedef enum logic [2:0] {
        OC_APPLIED = 3'd0,
        OC_BROKEN  = 3'd1,
        OC_FIXED   = 3'd2,
        OC_ZERO    = 3'd3,
        OC_BREAK   = 3'd4
    } t_outcome;

    typedef enum logic [2:0] {
        MS_SQ  = 3'd0,
        MS_DOT = 3'd1,
        MS_KS  = 3'd2,
        MS_CVL = 3'd3,
        MS_CVH = 3'd4,
        MS_TUL = 3'd5,
        MS_TUH = 3'd6
    } t_msel;

    typedef struct packed {
        logic signed [31:0] rel_x;
        logic signed [31:0] rel_y;
        logic signed [31:0] rel_z;
        logic signed [31:0] rel_vx;
        logic signed [31:0] rel_vy;
        logic signed [31:0] rel_vz;
        logic               top_movable;
        logic               bottom_movable;
    } t_in;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               apply_top;
        logic               apply_bottom;
        logic signed [31:0] stretch_out;
        logic               broken_out;
        t_outcome           outcome;
        logic [IDX_W-1:0]   top_target;
        logic [IDX_W-1:0]   bottom_target;
    } t_out;

    typedef struct packed {
        logic       load;
        logic       pre;
        logic       sq_init;
        logic       sq_step;
        logic       chk;
        logic       clr_acc;
        logic       va_start;
        logic       u_start;
        logic       mul_en;
        t_msel      msel;
        logic [1:0] axis;
        logic       dcap;
        logic       tsum;
        logic       fstore;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic early;
        logic len_zero;
        logic brk;
        logic div_done;
        logic out_busy;
    } t_stat;

endpackage

// ===== src/damped_spring_force_3d.sv =====
// Top level of the damped 3-D spring force block.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_in  (dsf3d_pkg::t_in)
// result    out        o_out_valid / i_out_ready    o_out (dsf3d_pkg::t_out)
// config    in         i_cfg_we (no wait)           i_cfg_idx, i_cfg_wdata
//
// One item is in flight at a time. A full item runs four 64-step divisions on the
// bit-serial divider (axial velocity and three unit vector components) and a
// 32-step square root before its result is loaded. Items skipped because the
// spring is broken or both ends are fixed go straight to the result after the
// early check; a zero length or a fresh break goes to the result after the
// stretch and break check.
// Reset is synchronous and active low; it restores the register defaults, clears
// the broken flag and the stored stretch, and empties the result register.
// A stalled result beat waits in the result register while the next input beat
// is taken; besides the time an item is in work, the block only stalls its input
// when a new result is ready and the previous one has still not been taken.

module damped_spring_force_3d (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  dsf3d_pkg::t_in   i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output dsf3d_pkg::t_out  o_out,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [31:0]      i_cfg_wdata
);

    // Command and status between the sequencer and the datapath.
    dsf3d_pkg::t_cmd  w_cmd;
    dsf3d_pkg::t_stat w_stat;

    // The sequencer steps through: squares, square root, stretch and break
    // check, dot product, axial velocity division, spring and damping terms,
    // then one division and two partial products per axis.
    dsf3d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the configuration, the spring state, one shared
    // 32 by 32 multiplier, the square root unit, the divider and the result
    // register.
    dsf3d_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

// ===== src/dsf3d_div.sv =====
// Bit-serial restoring divider, 64-bit dividend by 32-bit divisor.
`timescale 1ns / 1ps

module dsf3d_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot
);

    localparam int STEPS = 64;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [63:0]      r_q;
    logic [31:0]      r_rem;
    logic [31:0]      r_dvs;

    logic [32:0] w_sh;
    logic        w_ge;
    logic [32:0] w_diff;

    assign w_sh   = {r_rem, r_q[63]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[31:0] : w_sh[31:0];
            r_q   <= {r_q[62:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== src/dsf3d_ctrl.sv =====
// Sequencing state machine for the damped spring force block.
`timescale 1ns / 1ps

module dsf3d_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  dsf3d_pkg::t_stat i_stat,
    output dsf3d_pkg::t_cmd  o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_PRE  = 14'b00000000000010,
        S_SQ   = 14'b00000000000100,
        S_SQI  = 14'b00000000001000,
        S_SQRT = 14'b00000000010000,
        S_CHK  = 14'b00000000100000,
        S_DOT  = 14'b00000001000000,
        S_VAS  = 14'b00000010000000,
        S_VAW  = 14'b00000100000000,
        S_SD   = 14'b00001000000000,
        S_US   = 14'b00010000000000,
        S_UW   = 14'b00100000000000,
        S_F    = 14'b01000000000000,
        S_OUT  = 14'b10000000000000
    } t_state;

    t_state          r_state, n_state;
    logic [4:0]      r_cnt, n_cnt;
    logic [1:0]      r_axis, n_axis;
    dsf3d_pkg::t_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_axis  = r_axis;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_PRE;
                end
            end
            S_PRE: begin
                w_cmd.pre = 1'b1;
                n_cnt     = '0;
                n_state   = i_stat.early ? S_OUT : S_SQ;
            end
            S_SQ: begin
                if (r_cnt != 5'd3) begin
                    w_cmd.mul_en = 1'b1;
                    w_cmd.msel   = dsf3d_pkg::MS_SQ;
                    w_cmd.axis   = r_cnt[1:0];
                    n_cnt        = r_cnt + 5'd1;
                end else begin
                    n_state = S_SQI;
                end
            end
            S_SQI: begin
                w_cmd.sq_init = 1'b1;
                n_cnt         = '0;
                n_state       = S_SQRT;
            end
            S_SQRT: begin
                w_cmd.sq_step = 1'b1;
                n_cnt         = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                w_cmd.chk     = 1'b1;
                w_cmd.clr_acc = 1'b1;
                n_cnt         = '0;
                n_state       = (i_stat.len_zero || i_stat.brk) ? S_OUT : S_DOT;
            end
            S_DOT: begin
                if (r_cnt != 5'd3) begin
                    w_cmd.mul_en = 1'b1;
                    w_cmd.msel   = dsf3d_pkg::MS_DOT;
                    w_cmd.axis   = r_cnt[1:0];
                    n_cnt        = r_cnt + 5'd1;
                end else begin
                    n_state = S_VAS;
                end
            end
            S_VAS: begin
                w_cmd.va_start = 1'b1;
                n_state        = S_VAW;
            end
            S_VAW: begin
                if (i_stat.div_done) begin
                    n_cnt   = '0;
                    n_state = S_SD;
                end
            end
            S_SD: begin
                n_cnt = r_cnt + 5'd1;
                case (r_cnt)
                    5'd0: begin
                        w_cmd.mul_en = 1'b1;
                        w_cmd.msel   = dsf3d_pkg::MS_KS;
                    end
                    5'd1: begin
                        w_cmd.mul_en = 1'b1;
                        w_cmd.msel   = dsf3d_pkg::MS_CVL;
                    end
                    5'd2: begin
                        w_cmd.mul_en = 1'b1;
                        w_cmd.msel   = dsf3d_pkg::MS_CVH;
                    end
                    5'd4: w_cmd.dcap = 1'b1;
                    5'd5: begin
                        w_cmd.tsum = 1'b1;
                        n_axis     = '0;
                        n_state    = S_US;
                    end
                    default: ;
                endcase
            end
            S_US: begin
                w_cmd.u_start = 1'b1;
                w_cmd.axis    = r_axis;
                n_state       = S_UW;
            end
            S_UW: begin
                if (i_stat.div_done) begin
                    n_cnt   = '0;
                    n_state = S_F;
                end
            end
            S_F: begin
                n_cnt      = r_cnt + 5'd1;
                w_cmd.axis = r_axis;
                case (r_cnt)
                    5'd0: begin
                        w_cmd.mul_en = 1'b1;
                        w_cmd.msel   = dsf3d_pkg::MS_TUL;
                    end
                    5'd1: begin
                        w_cmd.mul_en = 1'b1;
                        w_cmd.msel   = dsf3d_pkg::MS_TUH;
                    end
                    5'd3: begin
                        w_cmd.fstore = 1'b1;
                        if (r_axis == 2'd2) begin
                            n_state = S_OUT;
                        end else begin
                            n_axis  = r_axis + 2'd1;
                            n_state = S_US;
                        end
                    end
                    default: ;
                endcase
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = w_cmd;

endmodule

// ===== src/dsf3d_dp.sv =====
// Datapath: registers, shared multiplier, square root, divider and result register.
`timescale 1ns / 1ps

module dsf3d_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dsf3d_pkg::t_in   i_in,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output dsf3d_pkg::t_out  o_out,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [31:0]      i_cfg_wdata,
    input  dsf3d_pkg::t_cmd  i_cmd,
    output dsf3d_pkg::t_stat o_stat
);

    localparam int FR = dsf3d_pkg::FRAC;
    localparam int IW = dsf3d_pkg::IDX_W;

    // configuration
    logic [31:0]   r_k, r_c;
    logic [30:0]   r_rest, r_blim;
    logic          r_ben;
    logic [IW-1:0] r_tidx, r_bidx;

    // persistent spring state
    logic        r_broken;
    logic [31:0] r_last_stretch;

    // current item
    logic [31:0] r_dm [3];
    logic [31:0] r_vm [3];
    logic [2:0]  r_dn, r_vn;
    logic        r_top, r_bot;
    dsf3d_pkg::t_outcome r_outcome;

    // arithmetic
    logic [63:0]      r_prod;
    dsf3d_pkg::t_msel r_ptag;
    logic [1:0]       r_pax;
    logic             r_pvld;
    logic [63:0]      r_pos, r_neg;
    logic [63:0]      r_sx, r_sres, r_sbit;
    logic [31:0]      r_s_mag;
    logic             r_s_neg;
    logic             r_va_neg;
    logic [63-FR:0]   r_spr;
    logic [95:0]      r_wacc;
    logic [60:0]      r_dmp;
    logic [61:0]      r_t;
    logic             r_t_neg;
    logic [30:0]      r_fm [3];
    logic [2:0]       r_fn;

    dsf3d_pkg::t_out r_out;
    logic            r_ovalid;

    // --- combinational helpers ---
    logic [31:0] w_len;
    logic        w_len_zero;
    logic        w_s_neg;
    logic [31:0] w_s_mag, w_s_sat, w_s_enc;
    logic        w_brk;
    logic [63:0] w_ssum;
    logic        w_va_neg;
    logic [63:0] w_diff;
    logic        w_div_start;
    logic [63:0] w_dividend;
    logic        w_div_done;
    logic [63:0] w_quot;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_mul;
    logic [95-FR:0] w_big;
    logic        w_spr_neg, w_dmp_neg;
    logic [61:0] w_spr_x, w_dmp_x, w_tmag;
    logic        w_tneg;
    logic [30:0] w_fm;
    logic        w_early;

    assign w_len      = r_sres[31:0];
    assign w_len_zero = (w_len == '0);
    assign w_s_neg    = (w_len < {1'b0, r_rest});
    assign w_s_mag    = w_s_neg ? ({1'b0, r_rest} - w_len) : (w_len - {1'b0, r_rest});
    assign w_s_sat    = w_s_mag[31] ? {1'b0, dsf3d_pkg::FORCE_MAX} : w_s_mag;
    assign w_s_enc    = w_s_neg ? (32'd0 - w_s_sat) : w_s_sat;
    assign w_brk      = !w_len_zero && !w_s_neg && (w_s_mag > {1'b0, r_blim}) && r_ben;
    assign w_ssum     = r_sres + r_sbit;
    assign w_early    = r_broken || (!r_top && !r_bot);

    assign w_va_neg   = (r_neg > r_pos);
    assign w_diff     = w_va_neg ? (r_neg - r_pos) : (r_pos - r_neg);
    assign w_div_start = i_cmd.va_start || i_cmd.u_start;
    assign w_dividend  = i_cmd.va_start ? w_diff : (64'(r_dm[i_cmd.axis]) << FR);

    dsf3d_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_len),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // shared 32x32 multiplier operand selection
    always_comb begin
        case (i_cmd.msel)
            dsf3d_pkg::MS_SQ: begin
                w_ma = r_dm[i_cmd.axis];
                w_mb = r_dm[i_cmd.axis];
            end
            dsf3d_pkg::MS_DOT: begin
                w_ma = r_vm[i_cmd.axis];
                w_mb = r_dm[i_cmd.axis];
            end
            dsf3d_pkg::MS_KS: begin
                w_ma = r_k;
                w_mb = r_s_mag;
            end
            dsf3d_pkg::MS_CVL: begin
                w_ma = r_c;
                w_mb = w_quot[31:0];
            end
            dsf3d_pkg::MS_CVH: begin
                w_ma = r_c;
                w_mb = w_quot[63:32];
            end
            dsf3d_pkg::MS_TUL: begin
                w_ma = r_t[31:0];
                w_mb = w_quot[31:0];
            end
            dsf3d_pkg::MS_TUH: begin
                w_ma = 32'(r_t[61:32]);
                w_mb = w_quot[31:0];
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mul = w_ma * w_mb;
    assign w_big = r_wacc[95:FR];

    // signed sum of spring and damping terms, doubled when one end is fixed
    always_comb begin
        w_spr_neg = !r_s_neg && (r_spr != '0);
        w_dmp_neg = !r_va_neg && (r_dmp != '0);
        w_spr_x   = 62'(r_spr);
        w_dmp_x   = 62'(r_dmp);
        if (w_spr_neg == w_dmp_neg) begin
            w_tmag = w_spr_x + w_dmp_x;
            w_tneg = w_spr_neg;
        end else if (w_spr_x >= w_dmp_x) begin
            w_tmag = w_spr_x - w_dmp_x;
            w_tneg = w_spr_neg;
        end else begin
            w_tmag = w_dmp_x - w_spr_x;
            w_tneg = w_dmp_neg;
        end
        if (r_top != r_bot) begin
            w_tmag = {w_tmag[60:0], 1'b0};
        end
    end

    assign w_fm = (w_big > (96-FR)'(dsf3d_pkg::FORCE_MAX)) ? dsf3d_pkg::FORCE_MAX : w_big[30:0];

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k            <= 32'd65536;
            r_c            <= '0;
            r_rest         <= 31'd65536;
            r_blim         <= 31'd65536;
            r_ben          <= 1'b0;
            r_tidx         <= '0;
            r_bidx         <= '0;
            r_broken       <= 1'b0;
            r_last_stretch <= '0;
            r_pvld         <= 1'b0;
            r_ovalid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dsf3d_pkg::CFG_STIFFNESS:   r_k    <= i_cfg_wdata;
                    dsf3d_pkg::CFG_DAMPING:     r_c    <= i_cfg_wdata;
                    dsf3d_pkg::CFG_REST_LENGTH: r_rest <= i_cfg_wdata[30:0];
                    dsf3d_pkg::CFG_BREAK_LIMIT: r_blim <= i_cfg_wdata[30:0];
                    dsf3d_pkg::CFG_BREAK_EN:    r_ben  <= i_cfg_wdata[0];
                    dsf3d_pkg::CFG_TOP_INDEX:   r_tidx <= i_cfg_wdata[IW-1:0];
                    dsf3d_pkg::CFG_BOT_INDEX:   r_bidx <= i_cfg_wdata[IW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.chk && !w_len_zero) begin
                r_last_stretch <= w_s_enc;
                if (w_brk) begin
                    r_broken <= 1'b1;
                end
            end
            r_pvld <= i_cmd.mul_en;
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dm[0] <= i_in.rel_x[31]  ? (32'd0 - i_in.rel_x)  : i_in.rel_x;
            r_dm[1] <= i_in.rel_y[31]  ? (32'd0 - i_in.rel_y)  : i_in.rel_y;
            r_dm[2] <= i_in.rel_z[31]  ? (32'd0 - i_in.rel_z)  : i_in.rel_z;
            r_vm[0] <= i_in.rel_vx[31] ? (32'd0 - i_in.rel_vx) : i_in.rel_vx;
            r_vm[1] <= i_in.rel_vy[31] ? (32'd0 - i_in.rel_vy) : i_in.rel_vy;
            r_vm[2] <= i_in.rel_vz[31] ? (32'd0 - i_in.rel_vz) : i_in.rel_vz;
            r_dn    <= {i_in.rel_z[31], i_in.rel_y[31], i_in.rel_x[31]};
            r_vn    <= {i_in.rel_vz[31], i_in.rel_vy[31], i_in.rel_vx[31]};
            r_top   <= i_in.top_movable;
            r_bot   <= i_in.bottom_movable;
            r_fm[0] <= '0;
            r_fm[1] <= '0;
            r_fm[2] <= '0;
            r_fn    <= '0;
        end
        if (i_cmd.pre) begin
            if (r_broken) begin
                r_outcome <= dsf3d_pkg::OC_BROKEN;
            end else if (!r_top && !r_bot) begin
                r_outcome <= dsf3d_pkg::OC_FIXED;
            end else begin
                r_outcome <= dsf3d_pkg::OC_APPLIED;
            end
        end
        if (i_cmd.load || i_cmd.clr_acc) begin
            r_pos <= '0;
            r_neg <= '0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_mul;
            r_ptag <= i_cmd.msel;
            r_pax  <= i_cmd.axis;
        end
        if (r_pvld) begin
            case (r_ptag)
                dsf3d_pkg::MS_SQ: r_pos <= r_pos + r_prod;
                dsf3d_pkg::MS_DOT: begin
                    if (r_vn[r_pax] != r_dn[r_pax]) begin
                        r_neg <= r_neg + r_prod;
                    end else begin
                        r_pos <= r_pos + r_prod;
                    end
                end
                dsf3d_pkg::MS_KS: r_spr <= r_prod[63:FR];
                dsf3d_pkg::MS_CVL, dsf3d_pkg::MS_TUL: r_wacc <= 96'(r_prod);
                dsf3d_pkg::MS_CVH, dsf3d_pkg::MS_TUH: r_wacc <= r_wacc + {r_prod, 32'd0};
                default: ;
            endcase
        end
        if (i_cmd.sq_init) begin
            r_sx   <= r_pos;
            r_sres <= '0;
            r_sbit <= 64'd1 << 62;
        end else if (i_cmd.sq_step) begin
            if (r_sx >= w_ssum) begin
                r_sx   <= r_sx - w_ssum;
                r_sres <= (r_sres >> 1) + r_sbit;
            end else begin
                r_sres <= r_sres >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end
        if (i_cmd.chk) begin
            r_s_mag <= w_s_mag;
            r_s_neg <= w_s_neg;
            if (w_len_zero) begin
                r_outcome <= dsf3d_pkg::OC_ZERO;
            end else if (w_brk) begin
                r_outcome <= dsf3d_pkg::OC_BREAK;
            end
        end
        if (i_cmd.va_start) begin
            r_va_neg <= w_va_neg;
        end
        if (i_cmd.dcap) begin
            r_dmp <= (w_big > (96-FR)'(dsf3d_pkg::TERM_CAP)) ? dsf3d_pkg::TERM_CAP : w_big[60:0];
        end
        if (i_cmd.tsum) begin
            r_t     <= w_tmag;
            r_t_neg <= w_tneg;
        end
        if (i_cmd.fstore) begin
            r_fm[i_cmd.axis] <= w_fm;
            r_fn[i_cmd.axis] <= (r_t_neg != r_dn[i_cmd.axis]) && (w_fm != '0);
        end
        if (i_cmd.out_load) begin
            r_out.force_x       <= r_fn[0] ? (32'd0 - {1'b0, r_fm[0]}) : {1'b0, r_fm[0]};
            r_out.force_y       <= r_fn[1] ? (32'd0 - {1'b0, r_fm[1]}) : {1'b0, r_fm[1]};
            r_out.force_z       <= r_fn[2] ? (32'd0 - {1'b0, r_fm[2]}) : {1'b0, r_fm[2]};
            r_out.apply_top     <= (r_outcome == dsf3d_pkg::OC_APPLIED) && r_top;
            r_out.apply_bottom  <= (r_outcome == dsf3d_pkg::OC_APPLIED) && r_bot;
            r_out.stretch_out   <= r_last_stretch;
            r_out.broken_out    <= r_broken;
            r_out.outcome       <= r_outcome;
            r_out.top_target    <= r_tidx;
            r_out.bottom_target <= r_bidx;
        end
    end

    assign o_stat.early    = w_early;
    assign o_stat.len_zero = w_len_zero;
    assign o_stat.brk      = w_brk;
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_busy = r_ovalid && !i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule

// ===== src/dsf3d_chk.sv =====
// Port-level checker for the damped spring force block, with its bind.
`timescale 1ns / 1ps
`include "damped_spring_force_3d_macros.svh"

module dsf3d_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input dsf3d_pkg::t_out o_out
);

    `DSF_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "result beat dropped or changed while stalled")
    `DSF_ASSERT_NEXT(a_one_at_a_time, i_in_valid && o_in_ready, !o_in_ready, "input taken while an item is in work")
    `DSF_ASSERT_SAME(a_skip_no_force, o_out_valid && (o_out.outcome != dsf3d_pkg::OC_APPLIED), !o_out.apply_top && !o_out.apply_bottom && (o_out.force_x == 32'sd0) && (o_out.force_y == 32'sd0) && (o_out.force_z == 32'sd0), "skipped item carries a force")
    `DSF_ASSERT_SAME(a_broken_flag, o_out_valid && ((o_out.outcome == dsf3d_pkg::OC_BROKEN) || (o_out.outcome == dsf3d_pkg::OC_BREAK)), o_out.broken_out, "broken outcome without broken flag")
    `DSF_ASSERT_SAME(a_applied_intact, o_out_valid && (o_out.outcome == dsf3d_pkg::OC_APPLIED), !o_out.broken_out, "force applied on a broken spring")

endmodule

bind damped_spring_force_3d dsf3d_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

// ===== bench/damped_spring_force_3d_test.sv =====
// Self-checking bench for the damped 3-D spring force block, with a predicting scoreboard.
`timescale 1ns / 1ps

module damped_spring_force_3d_test;

    import dsf3d_pkg::*;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  LONG_HOLD   = 3000;
    localparam int  DRAIN_WAIT  = 400;
    localparam logic [63:0] FORCE_CAP = 64'h7FFF_FFFF;
    localparam logic [63:0] PROD_CAP  = 64'h1000_0000_0000_0000;

    // The scoreboard keeps its own copy of the registers and of the spring
    // state, and turns each accepted input beat into the result beat it owes.
    class spring_forecast;
        logic [31:0] k_reg, c_reg;
        logic [30:0] rest_reg, limit_reg;
        logic        brk_en;
        logic [IDX_W-1:0] top_idx, bot_idx;
        logic        snapped;
        logic [31:0] stored_stretch;
        t_out        owed_forces[$];
        int          faults;
        int          seen;
        int          tally[5];

        function void clear();
            k_reg = 32'd65536;
            c_reg = '0;
            rest_reg = 31'd65536;
            limit_reg = 31'd65536;
            brk_en = 1'b0;
            top_idx = '0;
            bot_idx = '0;
            snapped = 1'b0;
            stored_stretch = '0;
            faults = 0;
            seen = 0;
            foreach (tally[i]) tally[i] = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [31:0] val);
            case (idx)
                CFG_STIFFNESS:   k_reg = val;
                CFG_DAMPING:     c_reg = val;
                CFG_REST_LENGTH: rest_reg = val[30:0];
                CFG_BREAK_LIMIT: limit_reg = val[30:0];
                CFG_BREAK_EN:    brk_en = val[0];
                CFG_TOP_INDEX:   top_idx = val[IDX_W-1:0];
                CFG_BOT_INDEX:   bot_idx = val[IDX_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] magnitude(logic [31:0] v);
            return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
        endfunction

        function logic [31:0] signed_word(logic neg, logic [63:0] mag);
            return neg ? (32'd0 - mag[31:0]) : mag[31:0];
        endfunction

        function logic [63:0] root_floor(logic [63:0] x);
            logic [63:0] res, bit_w;
            res = '0;
            bit_w = 64'd1 << 62;
            while (bit_w > x) bit_w = bit_w >> 2;
            while (bit_w != 0) begin
                if (x >= res + bit_w) begin
                    x = x - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
            return res;
        endfunction

        // Exact product, dropped by the fraction bits and capped.
        function logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
            logic [127:0] p;
            p = ({64'd0, a} * {64'd0, b}) >> FRAC;
            return (p > {64'd0, cap}) ? cap : p[63:0];
        endfunction

        function void note_offset(t_in x);
            logic [63:0] dm[3], vm[3], fm[3];
            logic        dn[3], vn[3], fn[3];
            logic [31:0] dw[3], vw[3];
            logic [63:0] sumsq, len, pos, neg, s_mag, sat, va_mag, spr, dmp, t_mag, u, p;
            logic        s_neg, va_neg, spr_neg, dmp_neg, t_neg;
            t_outcome    oc;
            t_out        r;
            dw[0] = x.rel_x;  dw[1] = x.rel_y;  dw[2] = x.rel_z;
            vw[0] = x.rel_vx; vw[1] = x.rel_vy; vw[2] = x.rel_vz;
            sumsq = 0; pos = 0; neg = 0;
            oc = OC_APPLIED;
            for (int i = 0; i < 3; i++) begin
                dm[i] = magnitude(dw[i]); dn[i] = dw[i][31];
                vm[i] = magnitude(vw[i]); vn[i] = vw[i][31];
                fm[i] = 0; fn[i] = 1'b0;
            end
            if (snapped) begin
                oc = OC_BROKEN;
            end else if (!x.top_movable && !x.bottom_movable) begin
                oc = OC_FIXED;
            end else begin
                for (int i = 0; i < 3; i++) sumsq = sumsq + dm[i] * dm[i];
                len = root_floor(sumsq);
                if (len == 0) begin
                    oc = OC_ZERO;
                end else begin
                    s_neg = len < {33'd0, rest_reg};
                    s_mag = s_neg ? ({33'd0, rest_reg} - len) : (len - {33'd0, rest_reg});
                    sat = (s_mag > FORCE_CAP) ? FORCE_CAP : s_mag;
                    stored_stretch = signed_word(s_neg, sat);
                    // The break test uses the exact stretch, not the stored one.
                    if (!s_neg && s_mag > {33'd0, limit_reg} && brk_en) begin
                        snapped = 1'b1;
                        oc = OC_BREAK;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            p = vm[i] * dm[i];
                            if (vn[i] != dn[i]) neg = neg + p;
                            else pos = pos + p;
                        end
                        va_neg = neg > pos;
                        va_mag = (va_neg ? neg - pos : pos - neg) / len;
                        spr = scaled_product({32'd0, k_reg}, s_mag, PROD_CAP);
                        spr_neg = !s_neg && spr != 0;
                        dmp = scaled_product({32'd0, c_reg}, va_mag, PROD_CAP);
                        dmp_neg = !va_neg && dmp != 0;
                        if (spr_neg == dmp_neg) begin
                            t_mag = spr + dmp; t_neg = spr_neg;
                        end else if (spr >= dmp) begin
                            t_mag = spr - dmp; t_neg = spr_neg;
                        end else begin
                            t_mag = dmp - spr; t_neg = dmp_neg;
                        end
                        // A fixed end puts the whole pull on the other ball.
                        if (x.top_movable != x.bottom_movable) t_mag = t_mag * 2;
                        for (int i = 0; i < 3; i++) begin
                            u = (dm[i] << FRAC) / len;
                            fm[i] = scaled_product(t_mag, u, FORCE_CAP);
                            fn[i] = (t_neg != dn[i]) && fm[i] != 0;
                        end
                    end
                end
            end
            r.force_x = signed_word(fn[0], fm[0]);
            r.force_y = signed_word(fn[1], fm[1]);
            r.force_z = signed_word(fn[2], fm[2]);
            r.apply_top = (oc == OC_APPLIED) && x.top_movable;
            r.apply_bottom = (oc == OC_APPLIED) && x.bottom_movable;
            r.stretch_out = stored_stretch;
            r.broken_out = snapped;
            r.outcome = oc;
            r.top_target = top_idx;
            r.bottom_target = bot_idx;
            tally[oc] = tally[oc] + 1;
            owed_forces.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                faults = faults + 1;
                $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_force(t_out got);
            t_out want;
            seen = seen + 1;
            if (owed_forces.size() == 0) begin
                faults = faults + 1;
                $display("%0t unexpected result beat: expected none, actual %h", $time, got);
                return;
            end
            want = owed_forces.pop_front();
            compare("force_x", want.force_x, got.force_x);
            compare("force_y", want.force_y, got.force_y);
            compare("force_z", want.force_z, got.force_z);
            compare("apply_top", want.apply_top, got.apply_top);
            compare("apply_bottom", want.apply_bottom, got.apply_bottom);
            compare("stretch_out", want.stretch_out, got.stretch_out);
            compare("broken_out", want.broken_out, got.broken_out);
            compare("outcome", want.outcome, got.outcome);
            compare("top_target", want.top_target, got.top_target);
            compare("bottom_target", want.bottom_target, got.bottom_target);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_wdata = '0;

    spring_forecast forecast;
    bit quiet = 1'b0;       // no idling on either side in the last part
    bit hold_req = 1'b0;    // asks the receiver for one long hold-off
    int cycles = 0;
    int sent = 0;

    damped_spring_force_3d dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog: a hung handshake must not keep the run going for ever.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, and a
    // check of every beat taken.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) forecast.check_force(o_out);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= i_rst_n;
            end
        end
    end

    // Offers one input beat and returns at the edge where it is taken. The
    // valid stays high from one beat into the next unless a gap is drawn.
    task automatic offer_beat(t_in x);
        int gap;
        gap = (!quiet && $urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= x;
        do @(posedge i_clk); while (!o_in_ready);
        forecast.note_offset(x);
        sent = sent + 1;
    endtask

    task automatic stop_offering();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every owed result has been taken, so the block is idle.
    task automatic wait_drained();
        while (forecast.owed_forces.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        forecast.write_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Component values that cover small springs, wide ranges and the extremes.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 6))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            2: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            3: return 32'd0;
            4: case ($urandom_range(0, 3))
                   0: return 32'h8000_0000;
                   1: return 32'h7FFF_FFFF;
                   2: return 32'hFFFF_FFFF;
                   default: return 32'd1;
               endcase
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    function automatic t_in random_spring();
        t_in x;
        x.rel_x = pick_word(); x.rel_y = pick_word(); x.rel_z = pick_word();
        x.rel_vx = pick_word(); x.rel_vy = pick_word(); x.rel_vz = pick_word();
        if ($urandom_range(0, 19) == 0) begin
            x.rel_x = '0; x.rel_y = '0; x.rel_z = '0;
        end
        // Both ends fixed only now and then; most beats reach the full path.
        x.top_movable = ($urandom_range(0, 9) != 0) ? 1'($urandom_range(0, 1)) : 1'b0;
        x.bottom_movable = x.top_movable ? 1'($urandom_range(0, 1))
                                         : ($urandom_range(0, 9) != 0);
        return x;
    endfunction

    function automatic t_in spring_of(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                      logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                      logic tm, logic bm);
        t_in x;
        x.rel_x = dx; x.rel_y = dy; x.rel_z = dz;
        x.rel_vx = vx; x.rel_vy = vy; x.rel_vz = vz;
        x.top_movable = tm; x.bottom_movable = bm;
        return x;
    endfunction

    task automatic random_batch(int count);
        repeat (count) offer_beat(random_spring());
        stop_offering();
        wait_drained();
    endtask

    task automatic random_registers();
        write_cfg(CFG_STIFFNESS, $urandom_range(0, 32'h0010_0000));
        write_cfg(CFG_DAMPING, $urandom);
        write_cfg(CFG_REST_LENGTH, $urandom_range(0, 32'h0040_0000));
        write_cfg(CFG_BREAK_LIMIT, $urandom);
        write_cfg(CFG_TOP_INDEX, $urandom);
        write_cfg(CFG_BOT_INDEX, $urandom);
    endtask

    initial begin
        forecast = new();
        forecast.clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats with the reset registers and a set damping: extremes of the
        // offsets and velocities, every flag pairing, zero length and a length at rest.
        write_cfg(CFG_DAMPING, 32'h0000_8000);
        offer_beat(spring_of(0, 0, 0, 32'h0001_0000, 0, 0, 1, 1));
        offer_beat(spring_of(32'h0002_0000, 0, 0, 0, 0, 0, 0, 0));
        offer_beat(spring_of(32'h0001_0000, 0, 0, 0, 0, 0, 1, 1));
        offer_beat(spring_of(32'h0000_8000, 0, 0, 0, 0, 0, 1, 1));
        offer_beat(spring_of(32'h0003_0000, 32'h0004_0000, 0, 32'h0001_0000, 0, 0, 1, 0));
        offer_beat(spring_of(0, 32'hFFFD_0000, 0, 0, 32'h0002_0000, 0, 0, 1));
        offer_beat(spring_of(0, 0, 32'h0000_0001, 0, 0, 32'hFFFF_FFFF, 1, 1));
        offer_beat(spring_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1));
        offer_beat(spring_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0));
        offer_beat(spring_of(32'h7FFF_FFFF, 32'h8000_0000, 0,
                             32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 1));
        offer_beat(spring_of(32'hFFFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0, 1, 1));
        offer_beat(spring_of(32'h0001_8000, 32'hFFFF_0000, 32'h0000_4000,
                             32'hFFF0_0000, 32'h0010_0000, 32'h0000_0001, 1, 1));
        offer_beat(spring_of(0, 0, 0, 0, 0, 0, 0, 1));
        offer_beat(spring_of(0, 0, 0, 0, 0, 0, 0, 0));
        stop_offering();
        wait_drained();

        // Moderate random registers; the receiver holds off for a long stretch
        // while the sender keeps offering, so the block backs up.
        random_registers();
        write_cfg(CFG_BREAK_EN, 0);
        hold_req = 1'b1;
        random_batch(300);

        // Low extremes, wrapped index writes and a write to an unused index.
        write_cfg(CFG_STIFFNESS, 0);
        write_cfg(CFG_DAMPING, 32'hFFFF_FFFF);
        write_cfg(CFG_REST_LENGTH, 0);
        write_cfg(CFG_BREAK_LIMIT, 0);
        write_cfg(CFG_TOP_INDEX, 32'hFFFF_FFFF);
        write_cfg(CFG_BOT_INDEX, 0);
        write_cfg(t_cfg_idx'(7), 32'hFFFF_FFFF);
        random_batch(250);

        // High extremes.
        write_cfg(CFG_STIFFNESS, 32'hFFFF_FFFF);
        write_cfg(CFG_DAMPING, 0);
        write_cfg(CFG_REST_LENGTH, 32'hFFFF_FFFF);
        write_cfg(CFG_BREAK_LIMIT, 32'h7FFF_FFFF);
        write_cfg(CFG_TOP_INDEX, 0);
        write_cfg(CFG_BOT_INDEX, 32'h0000_03FF);
        random_batch(250);

        random_registers();
        random_batch(250);

        // Last part without idling on either side.
        quiet = 1'b1;
        random_registers();
        random_batch(200);

        // Breaking is sticky and only a reset clears it, so it comes last: an
        // overstretch breaks the spring and later beats report it as broken.
        write_cfg(CFG_REST_LENGTH, 32'h0001_0000);
        write_cfg(CFG_BREAK_LIMIT, $urandom_range(32'h0004_0000, 32'h0100_0000));
        write_cfg(CFG_BREAK_EN, 1);
        offer_beat(spring_of(32'h0000_8000, 0, 0, 32'h0001_0000, 0, 0, 1, 1));
        offer_beat(spring_of(32'h7FFF_0000, 32'h7FFF_0000, 0, 0, 0, 0, 1, 1));
        offer_beat(spring_of(32'h0002_0000, 0, 0, 0, 0, 0, 1, 1));
        random_batch(80);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (forecast.owed_forces.size() != 0) begin
            forecast.faults = forecast.faults + forecast.owed_forces.size();
            $display("%0t results missing: expected %0d more, actual 0", $time,
                     forecast.owed_forces.size());
        end
        $display("Run covered %0d input beats and %0d result beats over %0d cycles.",
                 sent, forecast.seen, cycles);
        $display("Outcomes: applied %0d, broken %0d, both fixed %0d, zero length %0d, snap %0d.",
                 forecast.tally[0], forecast.tally[1], forecast.tally[2],
                 forecast.tally[3], forecast.tally[4]);
        if (forecast.faults == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== damped_spring_force_3d.f =====
+incdir+src
src/dsf3d_pkg.sv
src/dsf3d_div.sv
src/dsf3d_ctrl.sv
src/dsf3d_dp.sv
src/damped_spring_force_3d.sv
src/dsf3d_chk.sv
bench/damped_spring_force_3d_test.sv
